@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Geometry of the managed region.
  localparam int MAX_BLOCKS  = 4096;
  localparam int BLOCK_SHIFT = 9;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 13;
  localparam int TAG_W       = 15;
  localparam int SIZE_W      = 22;
  localparam int ADDR_W      = 32;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_BLOCKS = 2'd1;

  typedef enum logic [1:0] {
    TAG_FREE_START  = 2'b00,
    TAG_FREE_END    = 2'b01,
    TAG_ALLOC_START = 2'b10,
    TAG_ALLOC_END   = 2'b11
  } tag_kind_e;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_LARGEST = 2'd2,
    ACT_SPACE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_FRAGMENT  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_START = 3'd4,
    ST_CORRUPT   = 3'd5
  } status_e;

  // One boundary tag: kind and length or back-index.
  typedef struct packed {
    tag_kind_e        kind;
    logic [CNT_W-1:0] val;
  } tag_t;

  // Request from the sequencer to the tag memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    tag_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Table re-initialization order from the register file.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] blocks;
  } reinit_t;

  // One finished result word.
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] bytes;
  } result_t;

endpackage

@@ rtl/bfa_ram.sv @@
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bfa_engine.sv @@
// ----------------------------------------------------------------------------
// bfa_engine
// Sequencer that walks, splits and merges runs in the boundary-tag memory.
// ----------------------------------------------------------------------------
module bfa_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfa_pkg::reinit_t             reinit_i,
  input  logic [bfa_pkg::ADDR_W-1:0]   base_i,
  input  logic [bfa_pkg::CNT_W-1:0]    blocks_i,
  input  logic                         in_valid_i,
  input  bfa_pkg::action_e             in_action_i,
  input  logic [bfa_pkg::SIZE_W-1:0]   in_size_i,
  input  logic [bfa_pkg::ADDR_W-1:0]   in_addr_i,
  output logic                         in_stall_o,
  output bfa_pkg::mem_req_t            mem_o,
  input  bfa_pkg::tag_t                mem_rdata_i,
  output logic                         res_valid_o,
  output bfa_pkg::result_t             res_o,
  input  logic                         res_take_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_AWR, S_FS, S_FEND, S_FPREV, S_FWR, S_DONE
  } state_e;

  localparam int CW = bfa_pkg::CNT_W;
  localparam int IW = bfa_pkg::IDX_W;
  localparam int SH = bfa_pkg::BLOCK_SHIFT;
  localparam int SIZE_W_PAD = bfa_pkg::SIZE_W;

  state_e           state_q, state_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [1:0]       wstep_q, wstep_d;
  bfa_pkg::action_e act_q, act_d;
  logic [CW-1:0]    i_q, i_d;
  logic             found_q, found_d;
  logic [IW-1:0]    best_q, best_d;
  logic [CW-1:0]    blen_q, blen_d;
  logic [CW-1:0]    largest_q, largest_d;
  logic [CW-1:0]    need_q, need_d;
  logic [IW-1:0]    s_q, s_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    end_q, end_d;
  logic [IW-1:0]    start_q, start_d;
  logic [CW-1:0]    fbc_q, fbc_d;
  bfa_pkg::result_t res_q, res_d;

  // Next-state logic of the sequencer.
  always_comb begin
    logic [CW-1:0]     len;
    logic [CW-1:0]     nxt;
    logic [CW-1:0]     span;
    logic [SIZE_W_PAD:0] sz_round;
    logic [bfa_pkg::ADDR_W-1:0] off;
    logic              stop;
    bfa_pkg::tag_t     t;

    state_d   = state_q;
    cnt_d     = cnt_q;
    wstep_d   = wstep_q;
    act_d     = act_q;
    i_d       = i_q;
    found_d   = found_q;
    best_d    = best_q;
    blen_d    = blen_q;
    largest_d = largest_q;
    need_d    = need_q;
    s_d       = s_q;
    len_d     = len_q;
    end_d     = end_q;
    start_d   = start_q;
    fbc_d     = fbc_q;
    res_d     = res_q;
    mem_o     = '0;
    t         = mem_rdata_i;
    len       = t.val;
    nxt       = '0;
    span      = '0;
    stop      = 1'b0;
    sz_round  = '0;
    off       = in_addr_i - base_i;

    case (state_q)
      // Sweep the whole memory after reset or a new block count.
      S_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = cnt_q;
        if (cnt_q == '0) begin
          mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_START, val: blocks_i};
        end else if (blocks_i > CW'(1) && {1'b0, cnt_q} == blocks_i - CW'(1)) begin
          mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_END, val: '0};
        end
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(bfa_pkg::MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take a word and start its operation.
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = in_action_i;
          res_d     = '0;
          i_d       = '0;
          found_d   = 1'b0;
          best_d    = '0;
          blen_d    = '0;
          largest_d = '0;
          case (in_action_i)
            bfa_pkg::ACT_ALLOC: begin
              sz_round = {1'b0, in_size_i} + (SIZE_W_PAD + 1)'((1 << SH) - 1);
              need_d   = sz_round[SH +: CW];
              if (in_size_i == '0 || in_size_i > {fbc_q, SH'(0)}) begin
                res_d.status = bfa_pkg::ST_NO_SPACE;
                state_d      = S_DONE;
              end else begin
                state_d = S_WALK;
              end
            end
            bfa_pkg::ACT_FREE: begin
              if (in_addr_i < base_i || off[SH-1:0] != '0 ||
                  off >= bfa_pkg::ADDR_W'({blocks_i, SH'(0)})) begin
                res_d.status = bfa_pkg::ST_RANGE;
                state_d      = S_DONE;
              end else begin
                s_d         = off[SH +: IW];
                mem_o.raddr = off[SH +: IW];
                state_d     = S_FS;
              end
            end
            bfa_pkg::ACT_LARGEST: begin
              need_d  = '0;
              state_d = S_WALK;
            end
            default: begin
              res_d.bytes = {fbc_q, SH'(0)};
              state_d     = S_DONE;
            end
          endcase
        end
      end

      // One run start per cycle; the next address comes from this tag.
      S_WALK: begin
        if (t.kind == bfa_pkg::TAG_FREE_END || t.kind == bfa_pkg::TAG_ALLOC_END ||
            len == '0 || len > blocks_i - i_q) begin
          res_d.status = bfa_pkg::ST_CORRUPT;
          state_d      = S_DONE;
        end else begin
          if (t.kind == bfa_pkg::TAG_FREE_START) begin
            if (len > largest_q) begin
              largest_d = len;
            end
            if (need_q != '0 && len >= need_q && (!found_q || len < blen_q)) begin
              found_d = 1'b1;
              best_d  = i_q[IW-1:0];
              blen_d  = len;
              stop    = (len == need_q);
            end
          end
          nxt         = i_q + len;
          i_d         = nxt;
          mem_o.raddr = nxt[IW-1:0];
          if (stop || nxt >= blocks_i) begin
            if (act_q == bfa_pkg::ACT_ALLOC) begin
              if (found_d) begin
                wstep_d = '0;
                state_d = S_AWR;
              end else begin
                res_d.status = bfa_pkg::ST_FRAGMENT;
                state_d      = S_DONE;
              end
            end else begin
              res_d.bytes = {largest_d, SH'(0)};
              state_d     = S_DONE;
            end
          end
        end
      end

      // Split the chosen run, one tag write per cycle.
      S_AWR: begin
        wstep_d = wstep_q + 2'd1;
        case (wstep_q)
          2'd0: begin
            mem_o.we    = 1'b1;
            mem_o.waddr = best_q;
            mem_o.wdata = '{kind: bfa_pkg::TAG_ALLOC_START, val: need_q};
          end
          2'd1: begin
            nxt         = {1'b0, best_q} + need_q - CW'(1);
            mem_o.we    = need_q > CW'(1);
            mem_o.waddr = nxt[IW-1:0];
            mem_o.wdata = '{kind: bfa_pkg::TAG_ALLOC_END, val: {1'b0, best_q}};
          end
          2'd2: begin
            nxt         = {1'b0, best_q} + need_q;
            mem_o.we    = blen_q != need_q;
            mem_o.waddr = nxt[IW-1:0];
            mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_START, val: blen_q - need_q};
          end
          default: begin
            nxt         = {1'b0, best_q} + blen_q - CW'(1);
            span        = {1'b0, best_q} + need_q;
            mem_o.we    = (blen_q - need_q) > CW'(1);
            mem_o.waddr = nxt[IW-1:0];
            mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_END, val: span};
            fbc_d       = (fbc_q >= need_q) ? fbc_q - need_q : '0;
            res_d.addr  = base_i + (bfa_pkg::ADDR_W'(best_q) << SH);
            state_d     = S_DONE;
          end
        endcase
      end

      // Start tag of the released run.
      S_FS: begin
        if (t.kind != bfa_pkg::TAG_ALLOC_START) begin
          res_d.status = bfa_pkg::ST_NOT_START;
          state_d      = S_DONE;
        end else if (len == '0 || len > blocks_i - {1'b0, s_q}) begin
          res_d.status = bfa_pkg::ST_CORRUPT;
          state_d      = S_DONE;
        end else begin
          len_d = len;
          nxt   = {1'b0, s_q} + len;
          end_d = nxt;
          if (nxt < blocks_i) begin
            mem_o.raddr = nxt[IW-1:0];
            state_d     = S_FEND;
          end else if (s_q != '0) begin
            mem_o.raddr = s_q - IW'(1);
            state_d     = S_FPREV;
          end else begin
            start_d = s_q;
            wstep_d = '0;
            state_d = S_FWR;
          end
        end
      end

      // Right neighbour: absorb it when it is free.
      S_FEND: begin
        if (t.kind == bfa_pkg::TAG_FREE_START &&
            (len == '0 || len > blocks_i - end_q)) begin
          res_d.status = bfa_pkg::ST_CORRUPT;
          state_d      = S_DONE;
        end else begin
          if (t.kind == bfa_pkg::TAG_FREE_START) begin
            end_d = end_q + len;
          end
          if (s_q != '0) begin
            mem_o.raddr = s_q - IW'(1);
            state_d     = S_FPREV;
          end else begin
            start_d = s_q;
            wstep_d = '0;
            state_d = S_FWR;
          end
        end
      end

      // Left neighbour: a one-block free run or the end of a longer one.
      S_FPREV: begin
        wstep_d = '0;
        state_d = S_FWR;
        start_d = s_q;
        if (t.kind == bfa_pkg::TAG_FREE_START) begin
          start_d = s_q - IW'(1);
        end else if (t.kind == bfa_pkg::TAG_FREE_END) begin
          if (t.val >= {1'b0, s_q}) begin
            res_d.status = bfa_pkg::ST_CORRUPT;
            state_d      = S_DONE;
          end else begin
            start_d = t.val[IW-1:0];
          end
        end
      end

      // Merge writes, in order so that later tags win on shared entries.
      S_FWR: begin
        wstep_d     = wstep_q + 2'd1;
        span        = end_q - {1'b0, start_q};
        mem_o.we    = 1'b1;
        mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_END, val: {1'b0, start_q}};
        case (wstep_q)
          2'd0: begin
            mem_o.waddr = s_q;
          end
          2'd1: begin
            mem_o.waddr = start_q;
            mem_o.wdata = '{kind: bfa_pkg::TAG_FREE_START, val: span};
          end
          default: begin
            nxt         = end_q - CW'(1);
            mem_o.we    = span > CW'(1);
            mem_o.waddr = nxt[IW-1:0];
            fbc_d       = fbc_q + len_q;
            state_d     = S_DONE;
          end
        endcase
      end

      // Hold the result until the output register takes it.
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A new block count restarts the table from one free run.
    if (reinit_i.valid) begin
      state_d = S_CLEAR;
      cnt_d   = '0;
      fbc_d   = reinit_i.blocks;
    end
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      wstep_q <= '0;
      fbc_q   <= CW'(bfa_pkg::MAX_BLOCKS);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wstep_q <= wstep_d;
      fbc_q   <= fbc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    i_q       <= i_d;
    found_q   <= found_d;
    best_q    <= best_d;
    blen_q    <= blen_d;
    largest_q <= largest_d;
    need_q    <= need_d;
    s_q       <= s_d;
    len_q     <= len_d;
    end_q     <= end_d;
    start_q   <= start_d;
    res_q     <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

@@ rtl/best_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a memory of boundary tags, one tag per block.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  in      | input     | in_valid_i/stall   | action, size_bytes, address
//  out     | output    | out_valid_o/stall  | status, result_address, result_bytes
//  cfg     | input     | cfg_valid_i/ready  | cfg_index_i, cfg_data_i
//
// Allocate and the largest-run query walk the runs from block 0, one tag read
// a cycle through the tag memory port; a successful allocate then writes the
// split tags. Free reads the released start tag and its neighbours, then
// writes the merged tags; the free-space query and a rejected size need no
// walk. After reset and after each write of the block count register a
// clearing pass rewrites the whole tag memory; no input word is taken meanwhile.
// A stalled output holds its word; the next input word is still accepted.
module best_fit_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [bfa_pkg::SIZE_W-1:0] size_bytes_i,
  input  logic [bfa_pkg::ADDR_W-1:0] address_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [bfa_pkg::ADDR_W-1:0] result_address_o,
  output logic [bfa_pkg::SIZE_W-1:0] result_bytes_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [bfa_pkg::ADDR_W-1:0] cfg_data_i
);

  localparam int CW = bfa_pkg::CNT_W;

  logic [bfa_pkg::ADDR_W-1:0] base_q, base_d;
  logic [CW-1:0]              blocks_q, blocks_d;
  logic [CW-1:0]              blocks_new;
  bfa_pkg::reinit_t           reinit;
  bfa_pkg::mem_req_t          mem_req;
  logic [bfa_pkg::TAG_W-1:0]  mem_rdata;
  logic                       res_valid;
  logic                       res_take;
  bfa_pkg::result_t           res;
  logic                       out_valid_q, out_valid_d;
  bfa_pkg::result_t           out_q, out_d;

  // Register writes; the block count is clamped into range.
  always_comb begin
    blocks_new = cfg_data_i[CW-1:0];
    if (blocks_new == '0) begin
      blocks_new = CW'(1);
    end else if (blocks_new > CW'(bfa_pkg::MAX_BLOCKS)) begin
      blocks_new = CW'(bfa_pkg::MAX_BLOCKS);
    end
    base_d       = base_q;
    blocks_d     = blocks_q;
    reinit.valid = 1'b0;
    reinit.blocks = blocks_new;
    if (cfg_valid_i && cfg_index_i == bfa_pkg::CFG_BASE) begin
      base_d = cfg_data_i;
    end else if (cfg_valid_i && cfg_index_i == bfa_pkg::CFG_BLOCKS) begin
      blocks_d     = blocks_new;
      reinit.valid = 1'b1;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= bfa_pkg::ADDR_W'(32'h0400_0000);
      blocks_q <= CW'(bfa_pkg::MAX_BLOCKS);
    end else begin
      base_q   <= base_d;
      blocks_q <= blocks_d;
    end
  end

  // Tag memory.
  bfa_ram #(
    .WIDTH(bfa_pkg::TAG_W),
    .DEPTH(bfa_pkg::MAX_BLOCKS)
  ) u_tags (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  // Sequencer.
  bfa_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .reinit_i   (reinit),
    .base_i     (base_q),
    .blocks_i   (blocks_q),
    .in_valid_i (in_valid_i),
    .in_action_i(bfa_pkg::action_e'(action_i)),
    .in_size_i  (size_bytes_i),
    .in_addr_i  (address_i),
    .in_stall_o (in_stall_o),
    .mem_o      (mem_req),
    .mem_rdata_i(bfa_pkg::tag_t'(mem_rdata)),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take)
  );

  // Output register between the sequencer and the consumer.
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign result_address_o = out_q.addr;
  assign result_bytes_o   = out_q.bytes;

  // A failed operation reports no address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bfa_pkg::ST_OK |-> result_address_o == '0)
    else $error("failed operation carries an address");

  // A failed operation reports no byte count.
  a_fail_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bfa_pkg::ST_OK |-> result_bytes_o == '0)
    else $error("failed operation carries a byte count");

  // A new block count starts the clearing pass, which holds off input.
  a_reinit_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == bfa_pkg::CFG_BLOCKS |=> in_stall_o)
    else $error("input accepted during table clearing");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives allocate, free and query words through the stall handshake, mirrors
// the boundary-tag table in a scoreboard and checks every result word field
// by field, across several region sizes and base addresses.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int BLK_BYTES  = 512;
  localparam int CYCLE_CAP  = 20_000_000;
  localparam logic [21:0] BYTES_SAT = 22'h3FFFFF;

  // Mirror of the allocator: tag table, registers and pending result words.
  class alloc_scoreboard;
    tag_kind_e   tag_kind[MAX_BLOCKS];
    int unsigned tag_link[MAX_BLOCKS];
    int unsigned free_blocks;
    int unsigned nblocks;
    logic [31:0] base;
    result_t     expected_q[$];
    int unsigned live_blocks[$];
    int unsigned last_freed;
    int          errors;

    function new();
      base = 32'd67108864;
      nblocks = MAX_BLOCKS;
      errors = 0;
      last_freed = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        tag_kind[i] = TAG_FREE_START;
        tag_link[i] = 0;
      end
      tag_link[0] = nblocks;
      if (nblocks > 1) tag_kind[nblocks-1] = TAG_FREE_END;
      free_blocks = nblocks;
      live_blocks.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      int unsigned v;
      if (idx == CFG_BASE) begin
        base = data;
      end else if (idx == CFG_BLOCKS) begin
        v = data[12:0];
        if (v == 0) v = 1;
        if (v > MAX_BLOCKS) v = MAX_BLOCKS;
        nblocks = v;
        clear_table();
      end
    endfunction

    // Walks the runs from block 0; need of zero means no fit search.
    function bit walk_ok(int unsigned need, output bit found, output int unsigned best,
                         output int unsigned best_len, output int unsigned largest);
      int unsigned i;
      int unsigned len;
      i = 0;
      found = 0;
      best = 0;
      best_len = 0;
      largest = 0;
      while (i < nblocks) begin
        len = tag_link[i];
        if (tag_kind[i][0] || len == 0 || len > nblocks - i) return 0;
        if (tag_kind[i] == TAG_FREE_START) begin
          if (len > largest) largest = len;
          if (need != 0 && len >= need && (!found || len < best_len)) begin
            found = 1;
            best = i;
            best_len = len;
            if (len == need) break;
          end
        end
        i += len;
      end
      return 1;
    endfunction

    function status_e alloc_blocks(logic [21:0] size, output logic [31:0] addr);
      bit found;
      int unsigned best, bl, largest, need;
      addr = '0;
      if (size == 0 || longint'(size) > longint'(free_blocks) * BLK_BYTES)
        return ST_NO_SPACE;
      need = (int'(size) + BLK_BYTES - 1) / BLK_BYTES;
      if (!walk_ok(need, found, best, bl, largest)) return ST_CORRUPT;
      if (!found) return ST_FRAGMENT;
      tag_kind[best] = TAG_ALLOC_START;
      tag_link[best] = need;
      if (need > 1) begin
        tag_kind[best+need-1] = TAG_ALLOC_END;
        tag_link[best+need-1] = best;
      end
      if (bl != need) begin
        tag_kind[best+need] = TAG_FREE_START;
        tag_link[best+need] = bl - need;
        if (bl - need > 1) begin
          tag_kind[best+bl-1] = TAG_FREE_END;
          tag_link[best+bl-1] = best + need;
        end
      end
      free_blocks = free_blocks >= need ? free_blocks - need : 0;
      addr = base + best * BLK_BYTES;
      live_blocks.push_back(best);
      return ST_OK;
    endfunction

    function status_e release_blocks(logic [31:0] address);
      logic [31:0] off;
      int unsigned s, len, stop, start, nl, b;
      if (address < base) return ST_RANGE;
      off = address - base;
      if (off % BLK_BYTES != 0 || longint'(off) >= longint'(nblocks) * BLK_BYTES)
        return ST_RANGE;
      s = off / BLK_BYTES;
      if (tag_kind[s] != TAG_ALLOC_START) return ST_NOT_START;
      len = tag_link[s];
      if (len == 0 || len > nblocks - s) return ST_CORRUPT;
      stop = s + len;
      if (stop < nblocks && tag_kind[stop] == TAG_FREE_START) begin
        nl = tag_link[stop];
        if (nl == 0 || nl > nblocks - stop) return ST_CORRUPT;
        stop += nl;
      end
      start = s;
      if (s > 0) begin
        if (tag_kind[s-1] == TAG_FREE_START) begin
          start = s - 1;
        end else if (tag_kind[s-1] == TAG_FREE_END) begin
          b = tag_link[s-1];
          if (b >= s) return ST_CORRUPT;
          start = b;
        end
      end
      free_blocks += len;
      tag_kind[s] = TAG_FREE_END;
      tag_link[s] = start;
      tag_kind[start] = TAG_FREE_START;
      tag_link[start] = stop - start;
      if (stop - start > 1) begin
        tag_kind[stop-1] = TAG_FREE_END;
        tag_link[stop-1] = start;
      end
      foreach (live_blocks[k]) begin
        if (live_blocks[k] == s) begin
          live_blocks.delete(k);
          break;
        end
      end
      last_freed = s;
      return ST_OK;
    endfunction

    function logic [21:0] sat_bytes(int unsigned nblk);
      longint v;
      v = longint'(nblk) * BLK_BYTES;
      return v > BYTES_SAT ? BYTES_SAT : v[21:0];
    endfunction

    // Notes one accepted input word and queues the result it must produce.
    function void note_input(action_e act, logic [21:0] size, logic [31:0] address);
      result_t     r;
      bit          found;
      int unsigned best, bl, largest;
      logic [31:0] addr;
      r = '0;
      case (act)
        ACT_ALLOC: begin
          r.status = alloc_blocks(size, addr);
          r.addr = addr;
        end
        ACT_FREE: r.status = release_blocks(address);
        ACT_LARGEST: begin
          if (!walk_ok(0, found, best, bl, largest)) r.status = ST_CORRUPT;
          else r.bytes = sat_bytes(largest);
        end
        default: r.bytes = sat_bytes(free_blocks);
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    endtask

    // Checks one accepted result word against the oldest expectation.
    task check_result(logic [2:0] status, logic [31:0] addr, logic [21:0] bytes);
      result_t r;
      if (expected_q.size() == 0) begin
        report("unexpected result word", status, 0);
      end else begin
        r = expected_q.pop_front();
        if (status != r.status) report("status", status, r.status);
        if (addr != r.addr) report("result_address", addr, r.addr);
        if (bytes != r.bytes) report("result_bytes", bytes, r.bytes);
      end
    endtask
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic [1:0]        action_i = '0;
  logic [SIZE_W-1:0] size_bytes_i = '0;
  logic [ADDR_W-1:0] address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic [2:0]        status_o;
  logic [ADDR_W-1:0] result_address_o;
  logic [SIZE_W-1:0] result_bytes_o;
  logic              cfg_valid_i = 0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [ADDR_W-1:0] cfg_data_i = '0;

  alloc_scoreboard sb = new();
  bit              no_idle = 0;
  int              stall_left = 0;
  int              cycles = 0;

  best_fit_block_allocator uut (.*);

  always #5 clk_i = ~clk_i;

  function int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted words and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, result_address_o, result_bytes_o);
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sends one input word after a random gap and waits until it is taken.
  task send_word(action_e act, logic [21:0] size, logic [31:0] address);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    size_bytes_i <= size;
    address_i <= address;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, size, address);
  endtask

  task write_cfg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One random word: mostly allocate and free of live blocks, some noise.
  task random_word(int unsigned size_cap);
    int unsigned r, pick;
    logic [21:0] size;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r >= 45 && r < 80 && sb.live_blocks.size() != 0) begin
      pick = $urandom_range(0, sb.live_blocks.size() - 1);
      send_word(ACT_FREE, $urandom, sb.base + sb.live_blocks[pick] * BLK_BYTES);
    end else if (r >= 80 && r < 88) begin
      case ($urandom_range(0, 3))
        0: a = $urandom;
        1: a = sb.base + $urandom_range(0, sb.nblocks - 1) * BLK_BYTES;
        2: a = $urandom_range(0, 1) ? sb.base + sb.nblocks * BLK_BYTES : sb.base - BLK_BYTES;
        default: a = sb.base + sb.last_freed * BLK_BYTES;
      endcase
      send_word(ACT_FREE, $urandom, a);
    end else if (r >= 88 && r < 94) begin
      send_word(ACT_LARGEST, $urandom, $urandom);
    end else if (r >= 94) begin
      send_word(ACT_SPACE, $urandom, $urandom);
    end else begin
      case ($urandom_range(0, 19))
        0: size = 0;
        1: size = $urandom;
        2: size = $urandom_range(1, size_cap / BLK_BYTES + 1) * BLK_BYTES;
        default: size = $urandom_range(1, size_cap);
      endcase
      send_word(ACT_ALLOC, size, $urandom);
    end
  endtask

  initial begin
    logic [31:0] b;
    logic [31:0] phase_base[7];
    logic [31:0] phase_blocks[7];
    int unsigned cap;
    phase_base   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5600, 32'hFFFF_F000,
                     32'h0, 32'h8000_0000, 32'h0};
    phase_blocks = '{32'd0, 32'd8, 32'd16, 32'd3, 32'd32, 32'd8191, 32'd64};
    phase_base[4] = {$urandom} & 32'hFFFF_FE00;
    phase_base[6] = $urandom;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset configuration.
    b = sb.base;
    send_word(ACT_ALLOC, 22'd0, 32'd0);
    send_word(ACT_ALLOC, 22'd1, 32'd0);
    send_word(ACT_ALLOC, 22'd512, 32'd0);
    send_word(ACT_ALLOC, 22'd513, 32'd0);
    send_word(ACT_ALLOC, 22'h3FFFFF, 32'hFFFF_FFFF);
    send_word(ACT_LARGEST, 22'h3FFFFF, 32'hFFFF_FFFF);
    send_word(ACT_SPACE, 22'd0, 32'd0);
    send_word(ACT_FREE, 22'd0, 32'd0);
    send_word(ACT_FREE, 22'd0, b + 1);
    send_word(ACT_FREE, 22'd0, b + 4096 * BLK_BYTES);
    send_word(ACT_FREE, 22'd0, b + 100 * BLK_BYTES);
    send_word(ACT_FREE, 22'd0, b + 2 * BLK_BYTES + BLK_BYTES);
    send_word(ACT_FREE, 22'd0, b);
    send_word(ACT_FREE, 22'd0, b);
    send_word(ACT_FREE, 22'd0, b + BLK_BYTES);
    send_word(ACT_ALLOC, 22'd2097152, 32'd0);
    send_word(ACT_FREE, 22'd0, b + 2 * BLK_BYTES);
    send_word(ACT_ALLOC, 22'd2097152, 32'd0);
    send_word(ACT_LARGEST, 22'd0, 32'd0);
    send_word(ACT_ALLOC, 22'd1, 32'd0);
    send_word(ACT_FREE, 22'd0, b);
    send_word(ACT_SPACE, 22'd0, 32'd0);
    for (int i = 0; i < 60; i++) random_word(64 * BLK_BYTES);
    wait_drained();

    // Random phases over several region sizes and bases.
    for (int p = 0; p < 7; p++) begin
      no_idle = (p % 3 == 1);
      write_cfg(CFG_BASE, phase_base[p]);
      write_cfg(CFG_BLOCKS, phase_blocks[p]);
      cap = sb.nblocks > 256 ? 64 * BLK_BYTES : sb.nblocks * BLK_BYTES / 3 + 1;
      for (int i = 0; i < 82; i++) random_word(cap);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
